@@ hw/rtl/c8ie_pkg.sv @@
// ----------------------------------------------------------------------------
// CHIP-8 executor package
// Shared constants, codes, state and command types, and a helper function.
// ----------------------------------------------------------------------------
package c8ie_pkg;

   localparam int MEM_BYTES           = 4096;
   localparam int ADDR_W              = 12;
   localparam int STACK_DEPTH_DEF     = 16;
   localparam int SCREEN_WIDTH_DEF    = 64;
   localparam int SCREEN_HEIGHT_DEF   = 32;
   localparam int PC_START_DEF        = 512;

   localparam logic [15:0] SEED_RESET = 16'hACE1;
   localparam logic [15:0] SEED_ZERO  = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS  = 16'hB400;

   localparam logic [2:0] ACT_STEP  = 3'd0;
   localparam logic [2:0] ACT_TICK  = 3'd1;
   localparam logic [2:0] ACT_KEY   = 3'd2;
   localparam logic [2:0] ACT_LOAD  = 3'd3;
   localparam logic [2:0] ACT_PIXEL = 3'd4;

   typedef enum logic [2:0] {
      STS_OK, STS_UNKNOWN, STS_KEYWAIT, STS_STACK, STS_HALTED
   } c8ie_status_type;

   typedef enum logic [2:0] {
      KIND_PLAIN, KIND_DRAW, KIND_BCD, KIND_DUMP, KIND_FILL
   } c8ie_kind_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_PIX_SEL, S_FETCH_HI, S_FETCH_LO, S_OPCODE, S_REG_RD,
      S_EXEC, S_DRAW_MEM, S_DRAW_FB, S_DRAW_WR, S_DRAW_END, S_BCD, S_DUMP_RD,
      S_DUMP_WR, S_FILL_RD, S_FILL_WR, S_FINISH
   } c8ie_state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_CAPTURE, CMD_ACT, CMD_HALTED, CMD_PIX_RD, CMD_PIX_SEL,
      CMD_FETCH_HI, CMD_FETCH_LO, CMD_OPCODE, CMD_REG_RD, CMD_EXEC, CMD_DRAW_MEM,
      CMD_DRAW_FB, CMD_DRAW_WR, CMD_DRAW_END, CMD_BCD, CMD_DUMP_RD, CMD_DUMP_WR,
      CMD_FILL_RD, CMD_FILL_WR, CMD_FINISH
   } c8ie_cmd_type;

   typedef struct packed {
      c8ie_cmd_type cmd;
   } c8ie_ctrl_type;

   typedef struct packed {
      logic [2:0]    action;
      logic          halted;
      logic          fault;
      c8ie_kind_type kind;
      logic          last;
      logic          empty;
   } c8ie_stat_type;

   // value modulo a small modulus, valid while value < 16 * modulus
   function automatic logic [7:0] mod_small(input logic [7:0] value,
                                            input logic [7:0] modulus);
      logic [11:0] rem;
      logic [11:0] part;
      rem = {4'b0, value};
      for (int k = 3; k >= 0; k--) begin
         part = {4'b0, modulus} << k;
         if (rem >= part) begin
            rem = rem - part;
         end
      end
      return rem[7:0];
   endfunction

endpackage

@@ hw/rtl/chip8_instruction_executor_core.sv @@
// A step runs dispatch, fetch high and low, opcode, register read and execute;
// a draw adds a memory read, framebuffer read and write per sprite row and an
// end state, Fx33 a write per digit, Fx55/Fx65 a read and write per register.
// Others run dispatch and finish, a pixel read adds a select; one item at a time.
// Reset is synchronous and clears all machine state; memory and stack contents
// stay undefined, the framebuffer reads as off through per-row valid bits.
// ----------------------------------------------------------------------------
// CHIP-8 instruction executor core
// Top level: controller, datapath and the always-ready seed register port.
// ----------------------------------------------------------------------------
module chip8_instruction_executor_core #(
   parameter int STACK_DEPTH   = c8ie_pkg::STACK_DEPTH_DEF,
   parameter int SCREEN_WIDTH  = c8ie_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = c8ie_pkg::SCREEN_HEIGHT_DEF,
   parameter int PC_START      = c8ie_pkg::PC_START_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [11:0] req_load_address,
   input  logic [7:0]  req_load_byte,
   input  logic [3:0]  req_key_number,
   input  logic        req_key_down,
   input  logic [5:0]  req_pixel_x,
   input  logic [4:0]  req_pixel_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [11:0] rsp_pc_value,
   output logic        rsp_beep,
   output logic        rsp_collision,
   output logic        rsp_pixel_on,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_random_seed
);
   import c8ie_pkg::*;

   c8ie_ctrl_type ctrl;
   c8ie_stat_type stat;

   assign csr_ready = 1'b1;

   c8ie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   c8ie_dp #(
      .STACK_DEPTH   (STACK_DEPTH),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .PC_START      (PC_START)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_action       (req_action),
      .req_load_address (req_load_address),
      .req_load_byte    (req_load_byte),
      .req_key_number   (req_key_number),
      .req_key_down     (req_key_down),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .csr_wr           (csr_valid),
      .csr_random_seed  (csr_random_seed),
      .rsp_status       (rsp_status),
      .rsp_pc_value     (rsp_pc_value),
      .rsp_beep         (rsp_beep),
      .rsp_collision    (rsp_collision),
      .rsp_pixel_on     (rsp_pixel_on)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl.cmd == CMD_FINISH))
      else $error("result raised without a finish command");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      stat.halted |=> stat.halted)
      else $error("halt cleared without reset");

   a_exec_on_step: assert property (@(posedge clock) disable iff (reset)
      ctrl.cmd == CMD_EXEC |-> stat.action == ACT_STEP && !stat.halted)
      else $error("execute issued for a non-step item");
`endif

endmodule

@@ hw/rtl/c8ie_ctrl.sv @@
// ----------------------------------------------------------------------------
// CHIP-8 executor controller
// Sequences fetch, decode, execute and the draw, digit and copy loops; owns rsp valid.
// ----------------------------------------------------------------------------
module c8ie_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  c8ie_pkg::c8ie_stat_type stat,
   output c8ie_pkg::c8ie_ctrl_type ctrl
);
   import c8ie_pkg::*;

   c8ie_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctrl.cmd     = CMD_NONE;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.cmd = CMD_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.action == ACT_STEP) begin
               if (stat.halted) begin
                  ctrl.cmd = CMD_HALTED;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_FETCH_HI;
               end
            end else if (stat.action == ACT_PIXEL) begin
               ctrl.cmd = CMD_PIX_RD;
               state_in = S_PIX_SEL;
            end else begin
               ctrl.cmd = CMD_ACT;
               state_in = S_FINISH;
            end
         end
         S_PIX_SEL: begin
            ctrl.cmd = CMD_PIX_SEL;
            state_in = S_FINISH;
         end
         S_FETCH_HI: begin
            ctrl.cmd = CMD_FETCH_HI;
            state_in = S_FETCH_LO;
         end
         S_FETCH_LO: begin
            ctrl.cmd = CMD_FETCH_LO;
            state_in = S_OPCODE;
         end
         S_OPCODE: begin
            ctrl.cmd = CMD_OPCODE;
            state_in = S_REG_RD;
         end
         S_REG_RD: begin
            ctrl.cmd = CMD_REG_RD;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            ctrl.cmd = CMD_EXEC;
            if (stat.fault) begin
               state_in = S_FINISH;
            end else begin
               case (stat.kind)
                  KIND_DRAW: state_in = stat.empty ? S_DRAW_END : S_DRAW_MEM;
                  KIND_BCD:  state_in = S_BCD;
                  KIND_DUMP: state_in = S_DUMP_RD;
                  KIND_FILL: state_in = S_FILL_RD;
                  default:   state_in = S_FINISH;
               endcase
            end
         end
         S_DRAW_MEM: begin
            ctrl.cmd = CMD_DRAW_MEM;
            state_in = S_DRAW_FB;
         end
         S_DRAW_FB: begin
            ctrl.cmd = CMD_DRAW_FB;
            state_in = S_DRAW_WR;
         end
         S_DRAW_WR: begin
            ctrl.cmd = CMD_DRAW_WR;
            state_in = stat.last ? S_DRAW_END : S_DRAW_MEM;
         end
         S_DRAW_END: begin
            ctrl.cmd = CMD_DRAW_END;
            state_in = S_FINISH;
         end
         S_BCD: begin
            ctrl.cmd = CMD_BCD;
            if (stat.last) begin
               state_in = S_FINISH;
            end
         end
         S_DUMP_RD: begin
            ctrl.cmd = CMD_DUMP_RD;
            state_in = S_DUMP_WR;
         end
         S_DUMP_WR: begin
            ctrl.cmd = CMD_DUMP_WR;
            state_in = stat.last ? S_FINISH : S_DUMP_RD;
         end
         S_FILL_RD: begin
            ctrl.cmd = CMD_FILL_RD;
            state_in = S_FILL_WR;
         end
         S_FILL_WR: begin
            ctrl.cmd = CMD_FILL_WR;
            state_in = stat.last ? S_FINISH : S_FILL_RD;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.cmd     = CMD_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/c8ie_dp.sv @@
// ----------------------------------------------------------------------------
// CHIP-8 executor datapath
// Machine state, memory, return stack, framebuffer rows and execute logic.
// ----------------------------------------------------------------------------
module c8ie_dp #(
   parameter int STACK_DEPTH   = c8ie_pkg::STACK_DEPTH_DEF,
   parameter int SCREEN_WIDTH  = c8ie_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = c8ie_pkg::SCREEN_HEIGHT_DEF,
   parameter int PC_START      = c8ie_pkg::PC_START_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  c8ie_pkg::c8ie_ctrl_type ctrl,
   output c8ie_pkg::c8ie_stat_type stat,
   input  logic [2:0]              req_action,
   input  logic [11:0]             req_load_address,
   input  logic [7:0]              req_load_byte,
   input  logic [3:0]              req_key_number,
   input  logic                    req_key_down,
   input  logic [5:0]              req_pixel_x,
   input  logic [4:0]              req_pixel_y,
   input  logic                    csr_wr,
   input  logic [15:0]             csr_random_seed,
   output logic [2:0]              rsp_status,
   output logic [11:0]             rsp_pc_value,
   output logic                    rsp_beep,
   output logic                    rsp_collision,
   output logic                    rsp_pixel_on
);
   import c8ie_pkg::*;

   localparam int SW = $clog2(STACK_DEPTH);
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int XW = $clog2(SCREEN_WIDTH);
   localparam int YW = $clog2(SCREEN_HEIGHT);
   localparam int XP = XW + 1;

   // captured request
   logic [2:0]    action_ff;
   logic [11:0]   laddr_ff;
   logic [7:0]    lbyte_ff;
   logic [3:0]    keyn_ff;
   logic          keyd_ff;
   logic [XW-1:0] px_ff;
   logic [YW-1:0] py_ff;
   logic [7:0]    px_mod, py_mod;

   // machine state
   logic [11:0]   pc_ff, pc_in;
   logic [15:0]   i_ff, i_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [7:0]    delay_ff, delay_in;
   logic [7:0]    sound_ff, sound_in;
   logic [15:0]   keys_ff, keys_in;
   logic [7:0]    v_ff [16];
   logic [7:0]    v_in [16];
   logic [15:0]   lfsr_ff, lfsr_in, lfsr_nx;
   logic          halted_ff, halted_in;

   // working registers
   logic [7:0]    op_hi_ff, op_hi_in, op_lo_ff, op_lo_in;
   logic [7:0]    opa_ff, opa_in, opb_ff, opb_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [YW-1:0] row_ff, row_in;
   logic [XW-1:0] col_ff, col_in;
   logic [7:0]    sprite_ff, sprite_in;
   c8ie_status_type sts_ff, sts_in;
   logic          beep_ff, beep_in, hit_ff, hit_in, pix_ff, pix_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [11:0]   rsp_pc_ff, rsp_pc_in;
   logic          rsp_beep_ff, rsp_beep_in, rsp_hit_ff, rsp_hit_in;
   logic          rsp_pix_ff, rsp_pix_in;

   // memories
   logic [7:0]    mem_ram [MEM_BYTES];
   logic [7:0]    mem_rd_ff;
   logic          mem_we;
   logic [11:0]   mem_wa, mem_ra, addr_cnt;
   logic [7:0]    mem_wd;
   logic [11:0]   stk_ram [STACK_DEPTH];
   logic [11:0]   stk_rd_ff;
   logic [DW-1:0] depth_m1;
   logic [SCREEN_WIDTH-1:0] fb_ram [SCREEN_HEIGHT];
   logic [SCREEN_WIDTH-1:0] fb_rd_ff, fb_cur, fb_wd, sp_mask;
   logic [SCREEN_HEIGHT-1:0] fb_vld_ff;
   logic          fb_vld_rd_ff, fb_we, coll;
   logic [YW-1:0] fb_ra;

   // decode
   logic [15:0]   op;
   logic [3:0]    grp, fx, fy, fn;
   logic [7:0]    nn;
   logic [11:0]   nnn;
   logic [8:0]    sum9;
   logic [11:0]   pc2, pc4;
   c8ie_status_type e_sts;
   c8ie_kind_type e_kind;
   logic [11:0]   e_next;
   logic          e_wx, e_wf, e_iw, e_push, e_pop, e_cls, e_rnd, e_dly, e_snd;
   logic [7:0]    e_xd;
   logic          e_fd;
   logic [7:0]    e_xa, e_yb;
   logic [15:0]   e_id;
   logic          fault, go;
   logic [7:0]    col_mod, row_mod;

   // digits
   logic [7:0]    bcd_h, bcd_r, bcd_t, bcd_u, bcd_d;
   logic [15:0]   bcd_p;

   assign op   = {op_hi_ff, op_lo_ff};
   assign grp  = op[15:12];
   assign fx   = op[11:8];
   assign fy   = op[7:4];
   assign fn   = op[3:0];
   assign nn   = op[7:0];
   assign nnn  = op[11:0];
   assign sum9 = {1'b0, opa_ff} + {1'b0, opb_ff};
   assign pc2  = pc_ff + 12'd2;
   assign pc4  = pc_ff + 12'd4;
   assign lfsr_nx = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);
   assign addr_cnt = i_ff[11:0] + {8'b0, cnt_ff};
   assign depth_m1 = depth_ff - DW'(1);

   assign px_mod  = mod_small({2'b0, req_pixel_x}, 8'(SCREEN_WIDTH));
   assign py_mod  = mod_small({3'b0, req_pixel_y}, 8'(SCREEN_HEIGHT));
   assign col_mod = mod_small(opa_ff, 8'(SCREEN_WIDTH));
   assign row_mod = mod_small(opb_ff, 8'(SCREEN_HEIGHT));

   assign bcd_h = (opa_ff >= 8'd200) ? 8'd2 : ((opa_ff >= 8'd100) ? 8'd1 : 8'd0);
   assign bcd_r = opa_ff - bcd_h * 8'd100;
   assign bcd_p = {8'b0, bcd_r} * 16'd205;
   assign bcd_t = {3'b0, bcd_p[15:11]};
   assign bcd_u = bcd_r - bcd_t * 8'd10;
   assign bcd_d = (cnt_ff == 4'd0) ? bcd_h : ((cnt_ff == 4'd1) ? bcd_t : bcd_u);

   always_comb begin : exec_decode
      e_sts  = STS_OK;
      e_kind = KIND_PLAIN;
      e_next = pc2;
      e_wx   = 1'b0;
      e_xd   = 8'd0;
      e_wf   = 1'b0;
      e_fd   = 1'b0;
      e_xa   = opa_ff;
      e_yb   = opb_ff;
      e_iw   = 1'b0;
      e_id   = i_ff;
      e_push = 1'b0;
      e_pop  = 1'b0;
      e_cls  = 1'b0;
      e_rnd  = 1'b0;
      e_dly  = 1'b0;
      e_snd  = 1'b0;
      case (grp)
         4'h0: begin
            if (nn == 8'hE0) begin
               e_cls = 1'b1;
            end else if (nn == 8'hEE) begin
               if (depth_ff == '0) begin
                  e_sts = STS_STACK;
               end else begin
                  e_pop  = 1'b1;
                  e_next = stk_rd_ff + 12'd2;
               end
            end else begin
               e_sts = STS_UNKNOWN;
            end
         end
         4'h1: e_next = nnn;
         4'h2: begin
            if (depth_ff >= DW'(STACK_DEPTH)) begin
               e_sts = STS_STACK;
            end else begin
               e_push = 1'b1;
               e_next = nnn;
            end
         end
         4'h3: if (opa_ff == nn) e_next = pc4;
         4'h4: if (opa_ff != nn) e_next = pc4;
         4'h5: if (opa_ff == opb_ff) e_next = pc4;
         4'h6: begin
            e_wx = 1'b1;
            e_xd = nn;
         end
         4'h7: begin
            e_wx = 1'b1;
            e_xd = opa_ff + nn;
         end
         4'h8: begin
            e_wx = 1'b1;
            case (fn)
               4'h0: e_xd = opb_ff;
               4'h1: e_xd = opa_ff | opb_ff;
               4'h2: e_xd = opa_ff & opb_ff;
               4'h3: e_xd = opa_ff ^ opb_ff;
               4'h4: begin
                  e_wf = 1'b1;
                  e_fd = sum9[8];
                  e_xd = sum9[7:0];
               end
               // flag lands first, so an operand held in VF reads the new flag
               4'h5: begin
                  e_wf = 1'b1;
                  e_fd = opa_ff > opb_ff;
                  e_xa = (fx == 4'hF) ? {7'b0, e_fd} : opa_ff;
                  e_yb = (fy == 4'hF) ? {7'b0, e_fd} : opb_ff;
                  e_xd = e_xa - e_yb;
               end
               4'h6: begin
                  e_wf = 1'b1;
                  e_fd = opa_ff[0];
                  e_xa = (fx == 4'hF) ? {7'b0, e_fd} : opa_ff;
                  e_xd = e_xa >> 1;
               end
               4'h7: begin
                  e_wf = 1'b1;
                  e_fd = opb_ff > opa_ff;
                  e_xa = (fx == 4'hF) ? {7'b0, e_fd} : opa_ff;
                  e_yb = (fy == 4'hF) ? {7'b0, e_fd} : opb_ff;
                  e_xd = e_yb - e_xa;
               end
               4'hE: begin
                  e_wf = 1'b1;
                  e_fd = opa_ff[7];
                  e_xa = (fx == 4'hF) ? {7'b0, e_fd} : opa_ff;
                  e_xd = e_xa << 1;
               end
               default: e_sts = STS_UNKNOWN;
            endcase
         end
         4'h9: if (opa_ff != opb_ff) e_next = pc4;
         4'hA: begin
            e_iw = 1'b1;
            e_id = {4'b0, nnn};
         end
         4'hB: e_next = nnn + {4'b0, opb_ff};
         4'hC: begin
            e_rnd = 1'b1;
            e_wx  = 1'b1;
            e_xd  = lfsr_nx[7:0] & nn;
         end
         4'hD: e_kind = KIND_DRAW;
         4'hE: begin
            if (nn == 8'h9E) begin
               if (keys_ff[opa_ff[3:0]]) e_next = pc4;
            end else if (nn == 8'hA1) begin
               if (!keys_ff[opa_ff[3:0]]) e_next = pc4;
            end else begin
               e_sts = STS_UNKNOWN;
            end
         end
         4'hF: begin
            case (nn)
               8'h07: begin
                  e_wx = 1'b1;
                  e_xd = delay_ff;
               end
               8'h0A: e_sts = STS_KEYWAIT;
               8'h15: e_dly = 1'b1;
               8'h18: e_snd = 1'b1;
               8'h1E: begin
                  e_iw = 1'b1;
                  e_id = i_ff + {8'b0, opa_ff};
               end
               8'h29: begin
                  e_iw = 1'b1;
                  e_id = {8'b0, opa_ff} * 16'd5;
               end
               8'h33: e_kind = KIND_BCD;
               8'h55: e_kind = KIND_DUMP;
               8'h65: e_kind = KIND_FILL;
               default: e_sts = STS_UNKNOWN;
            endcase
         end
         default: e_sts = STS_UNKNOWN;
      endcase
   end

   assign fault = (e_sts != STS_OK);
   assign go    = (ctrl.cmd == CMD_EXEC) && !fault;

   always_comb begin
      stat.action = action_ff;
      stat.halted = halted_ff;
      stat.fault  = fault;
      stat.kind   = e_kind;
      stat.empty  = (fn == 4'd0);
      case (e_kind)
         KIND_DRAW: stat.last = (cnt_ff == fn - 4'd1);
         KIND_BCD:  stat.last = (cnt_ff == 4'd2);
         default:   stat.last = (cnt_ff == fx);
      endcase
   end

   // sprite row placed on a screen row, wrapping at the right edge
   always_comb begin
      logic [XP-1:0] pos;
      sp_mask = '0;
      for (int c = 0; c < 8; c++) begin
         pos = {1'b0, col_ff} + XP'(c);
         if (pos >= XP'(SCREEN_WIDTH)) begin
            pos = pos - XP'(SCREEN_WIDTH);
         end
         if (sprite_ff[7-c]) begin
            sp_mask[pos[XW-1:0]] = 1'b1;
         end
      end
   end

   assign fb_cur = fb_vld_rd_ff ? fb_rd_ff : '0;
   assign fb_wd  = fb_cur ^ sp_mask;
   assign coll   = |(fb_cur & sp_mask);
   assign fb_we  = (ctrl.cmd == CMD_DRAW_WR);
   assign fb_ra  = (ctrl.cmd == CMD_PIX_RD) ? py_ff : row_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_cnt;
      mem_wd = opa_ff;
      mem_ra = pc_ff;
      case (ctrl.cmd)
         CMD_FETCH_LO: mem_ra = pc_ff + 12'd1;
         CMD_DRAW_MEM, CMD_FILL_RD: mem_ra = addr_cnt;
         CMD_ACT: begin
            mem_we = (action_ff == ACT_LOAD);
            mem_wa = laddr_ff;
            mem_wd = lbyte_ff;
         end
         CMD_BCD: begin
            mem_we = 1'b1;
            mem_wd = bcd_d;
         end
         CMD_DUMP_WR: mem_we = 1'b1;
         default: mem_ra = pc_ff;
      endcase
   end

   always_comb begin
      pc_in         = pc_ff;
      i_in          = i_ff;
      depth_in      = depth_ff;
      delay_in      = delay_ff;
      sound_in      = sound_ff;
      keys_in       = keys_ff;
      v_in          = v_ff;
      lfsr_in       = lfsr_ff;
      halted_in     = halted_ff;
      op_hi_in      = op_hi_ff;
      op_lo_in      = op_lo_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      sprite_in     = sprite_ff;
      sts_in        = sts_ff;
      beep_in       = beep_ff;
      hit_in        = hit_ff;
      pix_in        = pix_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_beep_in   = rsp_beep_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_pix_in    = rsp_pix_ff;
      case (ctrl.cmd)
         CMD_CAPTURE: begin
            sts_in  = STS_OK;
            beep_in = 1'b0;
            hit_in  = 1'b0;
            pix_in  = 1'b0;
         end
         CMD_ACT: begin
            if (action_ff == ACT_TICK) begin
               if (delay_ff != 8'd0) delay_in = delay_ff - 8'd1;
               if (sound_ff != 8'd0) begin
                  sound_in = sound_ff - 8'd1;
                  beep_in  = (sound_ff == 8'd2);
               end
            end else if (action_ff == ACT_KEY) begin
               keys_in[keyn_ff] = keyd_ff;
            end
         end
         CMD_HALTED:   sts_in = STS_HALTED;
         CMD_PIX_SEL:  pix_in = fb_vld_rd_ff & fb_rd_ff[px_ff];
         CMD_FETCH_LO: op_hi_in = mem_rd_ff;
         CMD_OPCODE:   op_lo_in = mem_rd_ff;
         CMD_REG_RD: begin
            opa_in = v_ff[fx];
            opb_in = v_ff[(grp == 4'hB) ? 4'd0 : fy];
         end
         CMD_EXEC: begin
            if (fault) begin
               sts_in    = e_sts;
               halted_in = 1'b1;
            end else begin
               pc_in = e_next;
               if (e_wf) v_in[15] = {7'b0, e_fd};
               if (e_wx) v_in[fx] = e_xd;
               if (e_iw) i_in = e_id;
               if (e_push) depth_in = depth_ff + DW'(1);
               if (e_pop) depth_in = depth_m1;
               if (e_rnd) lfsr_in = lfsr_nx;
               if (e_dly) delay_in = opa_ff;
               if (e_snd) sound_in = opa_ff;
               col_in = col_mod[XW-1:0];
               row_in = row_mod[YW-1:0];
               cnt_in = 4'd0;
            end
         end
         CMD_DRAW_FB: sprite_in = mem_rd_ff;
         CMD_DRAW_WR: begin
            hit_in = hit_ff | coll;
            cnt_in = cnt_ff + 4'd1;
            row_in = (row_ff == YW'(SCREEN_HEIGHT - 1)) ? '0 : row_ff + YW'(1);
         end
         CMD_DRAW_END: v_in[15] = {7'b0, hit_ff};
         CMD_BCD:      cnt_in = cnt_ff + 4'd1;
         CMD_DUMP_RD:  opa_in = v_ff[cnt_ff];
         CMD_DUMP_WR:  cnt_in = cnt_ff + 4'd1;
         CMD_FILL_WR: begin
            v_in[cnt_ff] = mem_rd_ff;
            cnt_in       = cnt_ff + 4'd1;
         end
         CMD_FINISH: begin
            rsp_status_in = 3'(sts_ff);
            rsp_pc_in     = pc_ff;
            rsp_beep_in   = beep_ff;
            rsp_hit_in    = hit_ff;
            rsp_pix_in    = pix_ff;
         end
         default: pc_in = pc_ff;
      endcase
      if (csr_wr) begin
         lfsr_in = (csr_random_seed != 16'd0) ? csr_random_seed : SEED_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= 12'(PC_START);
         i_ff      <= 16'd0;
         depth_ff  <= '0;
         delay_ff  <= 8'd0;
         sound_ff  <= 8'd0;
         keys_ff   <= 16'd0;
         for (int r = 0; r < 16; r++) begin
            v_ff[r] <= 8'd0;
         end
         lfsr_ff   <= SEED_RESET;
         halted_ff <= 1'b0;
         fb_vld_ff <= '0;
      end else begin
         pc_ff     <= pc_in;
         i_ff      <= i_in;
         depth_ff  <= depth_in;
         delay_ff  <= delay_in;
         sound_ff  <= sound_in;
         keys_ff   <= keys_in;
         v_ff      <= v_in;
         lfsr_ff   <= lfsr_in;
         halted_ff <= halted_in;
         if (go && e_cls) begin
            fb_vld_ff <= '0;
         end else if (fb_we) begin
            fb_vld_ff[row_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.cmd == CMD_CAPTURE) begin
         action_ff <= req_action;
         laddr_ff  <= req_load_address;
         lbyte_ff  <= req_load_byte;
         keyn_ff   <= req_key_number;
         keyd_ff   <= req_key_down;
         px_ff     <= px_mod[XW-1:0];
         py_ff     <= py_mod[YW-1:0];
      end
      op_hi_ff      <= op_hi_in;
      op_lo_ff      <= op_lo_in;
      opa_ff        <= opa_in;
      opb_ff        <= opb_in;
      cnt_ff        <= cnt_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      sprite_ff     <= sprite_in;
      sts_ff        <= sts_in;
      beep_ff       <= beep_in;
      hit_ff        <= hit_in;
      pix_ff        <= pix_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_beep_ff   <= rsp_beep_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_pix_ff    <= rsp_pix_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem_ram[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (go && e_push) begin
         stk_ram[depth_ff[SW-1:0]] <= pc_ff;
      end
      stk_rd_ff <= stk_ram[depth_m1[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (fb_we) begin
         fb_ram[row_ff] <= fb_wd;
      end
      fb_rd_ff     <= fb_ram[fb_ra];
      fb_vld_rd_ff <= fb_vld_ff[fb_ra];
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_pc_value  = rsp_pc_ff;
   assign rsp_beep      = rsp_beep_ff;
   assign rsp_collision = rsp_hit_ff;
   assign rsp_pixel_on  = rsp_pix_ff;

endmodule

@@ tb/tb_chip8_instruction_executor_core.sv @@
// ----------------------------------------------------------------------------
// CHIP-8 instruction executor core testbench
// Builds short programs in memory through load transfers and single-steps
// them, mixed with timer ticks, key events and pixel reads. A scoreboard holds
// a full copy of the machine, predicts every result and checks each field.
// The seed register is rewritten between phases; the run ends with one halt.
// ----------------------------------------------------------------------------
module tb_chip8_instruction_executor_core;
   import c8ie_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int ITEM_COUNT  = 650;

   localparam logic [7:0] OP_CLS  = 8'hE0;
   localparam logic [7:0] OP_RET  = 8'hEE;
   localparam logic [7:0] OP_SKP  = 8'h9E;
   localparam logic [7:0] OP_SKNP = 8'hA1;
   localparam logic [7:0] OP_GDT  = 8'h07;
   localparam logic [7:0] OP_WKEY = 8'h0A;
   localparam logic [7:0] OP_SDT  = 8'h15;
   localparam logic [7:0] OP_SST  = 8'h18;
   localparam logic [7:0] OP_ADDI = 8'h1E;
   localparam logic [7:0] OP_FONT = 8'h29;
   localparam logic [7:0] OP_BCD  = 8'h33;
   localparam logic [7:0] OP_STOR = 8'h55;
   localparam logic [7:0] OP_LDR  = 8'h65;
   localparam logic [7:0] OP_BAD  = 8'h99;

   typedef struct {
      logic [2:0]  action;
      logic [11:0] load_address;
      logic [7:0]  load_byte;
      logic [3:0]  key_number;
      logic        key_down;
      logic [5:0]  pixel_x;
      logic [4:0]  pixel_y;
   } c8_request_t;

   typedef struct {
      logic [2:0]  status;
      logic [11:0] pc_value;
      logic        beep;
      logic        collision;
      logic        pixel_on;
   } c8_outcome_t;

   class Chip8Scoreboard;
      logic [7:0]  vreg[16];
      logic [15:0] index_val;
      logic [11:0] pc;
      logic [11:0] stack_mem[16];
      int          depth;
      logic [7:0]  delay_val;
      logic [7:0]  sound_val;
      bit          keys[16];
      logic [7:0]  mem[4096];
      bit          written[4096];
      bit          frame[2048];
      logic [15:0] lfsr;
      bit          halted;
      int          errors;
      c8_outcome_t pending[$];

      function new();
         foreach (vreg[i]) vreg[i] = 8'd0;
         foreach (keys[i]) keys[i] = 0;
         foreach (written[i]) written[i] = 0;
         foreach (frame[i]) frame[i] = 0;
         index_val = 16'd0;
         pc        = 12'(PC_START_DEF);
         depth     = 0;
         delay_val = 8'd0;
         sound_val = 8'd0;
         halted    = 0;
         errors    = 0;
         reseed(16'd44257);
      endfunction

      function void reseed(logic [15:0] s);
         lfsr = (s != 16'd0) ? s : SEED_ZERO;
      endfunction

      function logic [7:0] rd(int unsigned a);
         return mem[a & 12'hFFF];
      endfunction

      function void wr(int unsigned a, logic [7:0] b);
         mem[a & 12'hFFF]     = b;
         written[a & 12'hFFF] = 1;
      endfunction

      function logic [7:0] next_random();
         logic low;
         low  = lfsr[0];
         lfsr = lfsr >> 1;
         if (low) lfsr = lfsr ^ LFSR_TAPS;
         return lfsr[7:0];
      endfunction

      function c8ie_status_type execute(output bit hit);
         logic [15:0] op;
         logic [7:0]  nn;
         logic [8:0]  sum;
         int unsigned nxt, x, y, n, ox, oy, k;
         logic [7:0]  bits;
         hit = 0;
         op  = {rd(pc), rd(pc + 1)};
         nn  = op[7:0];
         n   = op[3:0];
         x   = op[11:8];
         y   = op[7:4];
         nxt = pc + 2;
         case (op[15:12])
            4'h0: begin
               if (nn == OP_CLS) begin
                  foreach (frame[i]) frame[i] = 0;
               end else if (nn == OP_RET) begin
                  if (depth == 0) return STS_STACK;
                  depth--;
                  nxt = stack_mem[depth] + 2;
               end else return STS_UNKNOWN;
            end
            4'h1: nxt = op[11:0];
            4'h2: begin
               if (depth >= 16) return STS_STACK;
               stack_mem[depth] = pc;
               depth++;
               nxt = op[11:0];
            end
            4'h3: if (vreg[x] == nn) nxt += 2;
            4'h4: if (vreg[x] != nn) nxt += 2;
            4'h5: if (vreg[x] == vreg[y]) nxt += 2;
            4'h6: vreg[x] = nn;
            4'h7: vreg[x] = vreg[x] + nn;
            4'h8: begin
               case (n)
                  0: vreg[x] = vreg[y];
                  1: vreg[x] = vreg[x] | vreg[y];
                  2: vreg[x] = vreg[x] & vreg[y];
                  3: vreg[x] = vreg[x] ^ vreg[y];
                  4: begin
                     sum = vreg[x] + vreg[y];
                     vreg[15] = {7'd0, sum[8]};
                     vreg[x] = sum[7:0];
                  end
                  5: begin
                     vreg[15] = {7'd0, vreg[x] > vreg[y]};
                     vreg[x] = vreg[x] - vreg[y];
                  end
                  6: begin
                     vreg[15] = {7'd0, vreg[x][0]};
                     vreg[x] = vreg[x] >> 1;
                  end
                  7: begin
                     vreg[15] = {7'd0, vreg[y] > vreg[x]};
                     vreg[x] = vreg[y] - vreg[x];
                  end
                  14: begin
                     vreg[15] = {7'd0, vreg[x][7]};
                     vreg[x] = vreg[x] << 1;
                  end
                  default: return STS_UNKNOWN;
               endcase
            end
            4'h9: if (vreg[x] != vreg[y]) nxt += 2;
            4'hA: index_val = {4'd0, op[11:0]};
            4'hB: nxt = op[11:0] + vreg[0];
            4'hC: vreg[x] = next_random() & nn;
            4'hD: begin
               ox = vreg[x];
               oy = vreg[y];
               vreg[15] = 8'd0;
               for (int row = 0; row < n; row++) begin
                  bits = rd(index_val + row);
                  for (int col = 0; col < 8; col++) begin
                     if (bits[7 - col]) begin
                        k = ((oy + row) % 32) * 64 + (ox + col) % 64;
                        if (frame[k]) begin
                           frame[k] = 0;
                           vreg[15] = 8'd1;
                           hit = 1;
                        end else frame[k] = 1;
                     end
                  end
               end
            end
            4'hE: begin
               if (nn == OP_SKP) begin
                  if (keys[vreg[x][3:0]]) nxt += 2;
               end else if (nn == OP_SKNP) begin
                  if (!keys[vreg[x][3:0]]) nxt += 2;
               end else return STS_UNKNOWN;
            end
            default: begin
               case (nn)
                  OP_GDT:  vreg[x] = delay_val;
                  OP_WKEY: return STS_KEYWAIT;
                  OP_SDT:  delay_val = vreg[x];
                  OP_SST:  sound_val = vreg[x];
                  OP_ADDI: index_val = index_val + vreg[x];
                  OP_FONT: index_val = vreg[x] * 16'd5;
                  OP_BCD: begin
                     wr(index_val, 8'(vreg[x] / 100));
                     wr(index_val + 1, 8'((vreg[x] % 100) / 10));
                     wr(index_val + 2, 8'(vreg[x] % 10));
                  end
                  OP_STOR: for (int i = 0; i <= x; i++) wr(index_val + i, vreg[i]);
                  OP_LDR:  for (int i = 0; i <= x; i++) vreg[i] = rd(index_val + i);
                  default: return STS_UNKNOWN;
               endcase
            end
         endcase
         pc = nxt[11:0];
         return STS_OK;
      endfunction

      function void note_request(c8_request_t r);
         c8_outcome_t e;
         bit hit;
         e = '{status: STS_OK, pc_value: 0, beep: 0, collision: 0, pixel_on: 0};
         case (r.action)
            ACT_STEP: begin
               if (halted) e.status = STS_HALTED;
               else begin
                  e.status = execute(hit);
                  e.collision = hit;
                  if (e.status != STS_OK) halted = 1;
               end
            end
            ACT_TICK: begin
               if (delay_val > 0) delay_val--;
               if (sound_val > 0) begin
                  sound_val--;
                  e.beep = (sound_val == 8'd1);
               end
            end
            ACT_KEY:   keys[r.key_number] = r.key_down;
            ACT_LOAD:  wr(r.load_address, r.load_byte);
            ACT_PIXEL: e.pixel_on = frame[r.pixel_y * 64 + r.pixel_x];
            default: ;
         endcase
         e.pc_value = pc;
         pending.insert(pending.size(), e);
      endfunction

      function void check_result(c8_outcome_t got);
         c8_outcome_t e;
         if (pending.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status);
            errors++;
         end
         if (got.pc_value !== e.pc_value) begin
            $error("pc_value: expected %0h, got %0h", e.pc_value, got.pc_value);
            errors++;
         end
         if (got.beep !== e.beep) begin
            $error("beep: expected %0b, got %0b", e.beep, got.beep);
            errors++;
         end
         if (got.collision !== e.collision) begin
            $error("collision: expected %0b, got %0b", e.collision, got.collision);
            errors++;
         end
         if (got.pixel_on !== e.pixel_on) begin
            $error("pixel_on: expected %0b, got %0b", e.pixel_on, got.pixel_on);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_action;
   logic [11:0] req_load_address;
   logic [7:0]  req_load_byte;
   logic [3:0]  req_key_number;
   logic        req_key_down;
   logic [5:0]  req_pixel_x;
   logic [4:0]  req_pixel_y;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [11:0] rsp_pc_value;
   logic        rsp_beep;
   logic        rsp_collision;
   logic        rsp_pixel_on;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_random_seed;

   Chip8Scoreboard machine = new();
   int cycle_count = 0;
   int burst_left  = 0;
   int stall_mode  = 0;
   int sent_count  = 0;

   chip8_instruction_executor_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_load_address (req_load_address),
      .req_load_byte    (req_load_byte),
      .req_key_number   (req_key_number),
      .req_key_down     (req_key_down),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_pc_value     (rsp_pc_value),
      .rsp_beep         (rsp_beep),
      .rsp_collision    (rsp_collision),
      .rsp_pixel_on     (rsp_pixel_on),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_random_seed  (csr_random_seed)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         machine.check_result('{status: rsp_status, pc_value: rsp_pc_value, beep: rsp_beep,
                                collision: rsp_collision, pixel_on: rsp_pixel_on});
      end
   end

   // receiver: free-running, random or periodic stalls, mode changes now and then
   always @(negedge clock) begin
      if (cycle_count % 256 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= (cycle_count % 16) < 11;
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic c8_request_t random_request(logic [2:0] action);
      c8_request_t r;
      r.action       = action;
      r.load_address = 12'($urandom);
      r.load_byte    = 8'($urandom);
      r.key_number   = 4'($urandom);
      r.key_down     = 1'($urandom);
      r.pixel_x      = 6'($urandom);
      r.pixel_y      = 5'($urandom);
      return r;
   endfunction

   // called at a falling edge; returns at a falling edge
   task automatic send_request(c8_request_t r);
      req_valid        <= 1'b1;
      req_action       <= r.action;
      req_load_address <= r.load_address;
      req_load_byte    <= r.load_byte;
      req_key_number   <= r.key_number;
      req_key_down     <= r.key_down;
      req_pixel_x      <= r.pixel_x;
      req_pixel_y      <= r.pixel_y;
      do @(posedge clock); while (!req_ready);
      machine.note_request(r);
      sent_count++;
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 12);
      end else burst_left--;
   endtask

   task automatic load_memory(int unsigned addr, logic [7:0] b);
      c8_request_t r;
      r = random_request(ACT_LOAD);
      r.load_address = addr[11:0];
      r.load_byte    = b;
      send_request(r);
   endtask

   task automatic fill_if_unwritten(int unsigned addr);
      if (!machine.written[addr & 12'hFFF]) load_memory(addr, 8'($urandom));
   endtask

   // place an opcode at PC, make sure its operand bytes exist, execute it
   task automatic run_opcode(logic [15:0] op);
      if (op[15:12] == 4'hD) begin
         for (int i = 0; i < op[3:0]; i++) fill_if_unwritten(machine.index_val + i);
      end
      if (op[15:12] == 4'hF && op[7:0] == OP_LDR) begin
         for (int i = 0; i <= op[11:8]; i++) fill_if_unwritten(machine.index_val + i);
      end
      load_memory(machine.pc, op[15:8]);
      load_memory(machine.pc + 1, op[7:0]);
      send_request(random_request(ACT_STEP));
   endtask

   task automatic write_seed(logic [15:0] s);
      req_valid <= 1'b0;
      while (machine.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_random_seed <= s;
      do @(posedge clock); while (!csr_ready);
      machine.reseed(s);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_opcode();
      logic [15:0] r;
      logic [7:0]  fsub[8];
      logic [3:0]  asub[9];
      fsub = '{OP_GDT, OP_SDT, OP_SST, OP_ADDI, OP_FONT, OP_BCD, OP_STOR, OP_LDR};
      asub = '{0, 1, 2, 3, 4, 5, 6, 7, 14};
      r = 16'($urandom);
      case ($urandom_range(0, 29))
         0:      r = {4'h0, r[11:8], OP_CLS};
         1:      r = (machine.depth > 0) ? {4'h0, r[11:8], OP_RET} : {4'h6, r[11:0]};
         2:      r = {4'h1, r[11:0]};
         3:      r = (machine.depth < 16) ? {4'h2, r[11:0]} : {4'h7, r[11:0]};
         4:      r = {4'h3, r[11:8], machine.vreg[r[11:8]]};
         5:      r[15:12] = 4'h4;
         6:      r[15:12] = 4'h5;
         7, 8:   r[15:12] = 4'h6;
         9:      r[15:12] = 4'h7;
         10, 11, 12, 13: r = {4'h8, r[11:4], asub[$urandom_range(0, 8)]};
         14:     r[15:12] = 4'h9;
         15:     r = {4'hA, 4'h0, r[7:0]};
         16:     r[15:12] = 4'hB;
         17:     r[15:12] = 4'hC;
         18, 19, 20: r[15:12] = 4'hD;
         21:     r = {4'hE, r[11:8], r[0] ? OP_SKP : OP_SKNP};
         default: r = {4'hF, r[11:8], fsub[$urandom_range(0, 7)]};
      endcase
      return r;
   endfunction

   task automatic random_phase(int items);
      int sel;
      int stop_at;
      stop_at = sent_count + items;
      while (sent_count < stop_at) begin
         sel = $urandom_range(0, 99);
         if (sel < 62) run_opcode(pick_opcode());
         else if (sel < 76) send_request(random_request(ACT_TICK));
         else if (sel < 85) send_request(random_request(ACT_KEY));
         else if (sel < 94) send_request(random_request(ACT_PIXEL));
         else if (sel < 98) send_request(random_request(ACT_LOAD));
         else send_request(random_request(3'($urandom_range(5, 7))));
      end
   endtask

   initial begin
      logic [15:0] directed_ops[$];
      c8_request_t r;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_action       <= ACT_STEP;
      req_load_address <= 12'd0;
      req_load_byte    <= 8'd0;
      req_key_number   <= 4'd0;
      req_key_down     <= 1'b0;
      req_pixel_x      <= 6'd0;
      req_pixel_y      <= 5'd0;
      rsp_ready        <= 1'b0;
      csr_valid        <= 1'b0;
      csr_random_seed  <= 16'd0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      r = random_request(ACT_KEY);
      r.key_number = 4'hF;
      r.key_down   = 1'b1;
      send_request(r);
      r = random_request(ACT_LOAD);
      r.load_address = 12'hFFF;
      r.load_byte    = 8'hFF;
      send_request(r);
      directed_ops = '{16'h00E0, 16'h60FF, 16'h6101, 16'h8014, 16'h8FF4, 16'h8017,
                       16'h801E, 16'h8016, 16'hC1FF, 16'hAFFE, 16'hD01F, 16'hE19E,
                       16'h2E00, 16'h00EE, 16'hF133, 16'h1FFE, 16'h7001};
      foreach (directed_ops[i]) run_opcode(directed_ops[i]);
      r = random_request(ACT_PIXEL);
      r.pixel_x = 6'd63;
      r.pixel_y = 5'd31;
      send_request(r);
      send_request(random_request(ACT_TICK));
      send_request(random_request(3'd7));

      random_phase(ITEM_COUNT / 5);
      write_seed(16'd1);
      random_phase(ITEM_COUNT / 5);
      write_seed(16'hFFFF);
      random_phase(ITEM_COUNT / 5);
      write_seed(16'd0);
      random_phase(ITEM_COUNT / 10);
      write_seed(16'($urandom));
      random_phase(ITEM_COUNT / 10);

      // finish on one fault; everything after it must report halted for steps
      case ($urandom_range(0, 3))
         0: run_opcode({4'hF, 4'($urandom), OP_BAD});
         1: run_opcode({4'hF, 4'($urandom), OP_WKEY});
         2: begin
            while (machine.depth > 0) run_opcode({4'h0, 4'($urandom), OP_RET});
            run_opcode({4'h0, 4'($urandom), OP_RET});
         end
         default: begin
            while (machine.depth < 16) run_opcode({4'h2, 12'($urandom)});
            run_opcode({4'h2, 12'($urandom)});
         end
      endcase
      for (int n = 0; n < 12; n++) send_request(random_request(3'($urandom_range(0, 4))));

      req_valid <= 1'b0;
      while (machine.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (machine.errors == 0 && machine.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
